// ----- hw/rtl/reload_down_counter_timer_assert.svh -----
// ----------------------------------------------------------------------------
// Reload down-counter timer assertion macros
// Concurrent assertion helpers clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef RELOAD_DOWN_COUNTER_TIMER_ASSERT_SVH
`define RELOAD_DOWN_COUNTER_TIMER_ASSERT_SVH

// Checked only outside reset.
`define RDCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define RDCT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/rdct_pkg.sv -----
// ----------------------------------------------------------------------------
// rdct_pkg
// Types, constants and helpers shared by the reload down-counter timer.
// ----------------------------------------------------------------------------
package rdct_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int FIELD_WIDTH = 24;
    localparam int WIDE_WIDTH  = (COUNT_WIDTH > FIELD_WIDTH) ? COUNT_WIDTH : FIELD_WIDTH;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] REG_CTRL    = 2'd0;
    localparam logic [1:0] REG_RELOAD  = 2'd1;
    localparam logic [1:0] REG_CURRENT = 2'd2;
    localparam logic [1:0] REG_ELAPSED = 2'd3;

    localparam int CTRL_EN_BIT   = 0;
    localparam int CTRL_IE_BIT   = 1;
    localparam int CTRL_CLK_BIT  = 2;
    localparam int CTRL_OS_BIT   = 3;
    localparam int CTRL_FLAG_BIT = 16;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [FIELD_WIDTH-1:0] field_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] reg_index;
        field_t     write_data;
    } req_t;

    typedef struct packed {
        field_t read_data;
        logic   irq_pulse;
    } rsp_t;

    function automatic field_t count_to_field(input count_t v);
        logic [WIDE_WIDTH-1:0] tmp;
        tmp = '0;
        tmp[COUNT_WIDTH-1:0] = v;
        return tmp[FIELD_WIDTH-1:0];
    endfunction

    function automatic count_t field_to_count(input field_t v);
        logic [WIDE_WIDTH-1:0] tmp;
        tmp = '0;
        tmp[FIELD_WIDTH-1:0] = v;
        return tmp[COUNT_WIDTH-1:0];
    endfunction

endpackage

// ----- hw/rtl/rdct_core.sv -----
// ----------------------------------------------------------------------------
// rdct_core
// Timer state and the request logic: tick, write, read.
// ----------------------------------------------------------------------------
module rdct_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  rdct_pkg::req_t req,
    output rdct_pkg::rsp_t rsp
);

    import rdct_pkg::*;

    count_t count_reg, count_next;
    count_t reload_reg, reload_next;
    logic   en_reg, en_next;
    logic   ie_reg, ie_next;
    logic   clk_sel_reg, clk_sel_next;
    logic   os_reg, os_next;
    logic   flag_reg, flag_next;

    count_t count_dec;
    count_t elapsed;
    field_t ctrl_read;

    assign count_dec = count_reg - count_t'(1);
    assign elapsed   = reload_reg - count_reg;

    always_comb
    begin
        ctrl_read                = '0;
        ctrl_read[CTRL_EN_BIT]   = en_reg;
        ctrl_read[CTRL_IE_BIT]   = ie_reg;
        ctrl_read[CTRL_CLK_BIT]  = clk_sel_reg;
        ctrl_read[CTRL_OS_BIT]   = os_reg;
        ctrl_read[CTRL_FLAG_BIT] = flag_reg;
    end

    always_comb
    begin
        count_next    = count_reg;
        reload_next   = reload_reg;
        en_next       = en_reg;
        ie_next       = ie_reg;
        clk_sel_next  = clk_sel_reg;
        os_next       = os_reg;
        flag_next     = flag_reg;
        rsp.read_data = '0;
        rsp.irq_pulse = 1'b0;
        case (req.req_type)
            REQ_TICK:
            begin
                if (en_reg)
                begin
                    if (count_reg == '0)
                    begin
                        count_next = reload_reg;
                    end
                    else
                    begin
                        count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            flag_next     = 1'b1;
                            rsp.irq_pulse = ie_reg;
                            if (os_reg)
                            begin
                                en_next     = 1'b0;
                                ie_next     = 1'b0;
                                reload_next = '0;
                            end
                        end
                    end
                end
            end
            REQ_WRITE:
            begin
                case (req.reg_index)
                    REG_CTRL:
                    begin
                        en_next      = req.write_data[CTRL_EN_BIT];
                        ie_next      = req.write_data[CTRL_IE_BIT];
                        clk_sel_next = req.write_data[CTRL_CLK_BIT];
                        os_next      = req.write_data[CTRL_OS_BIT];
                    end
                    REG_RELOAD:
                    begin
                        reload_next = field_to_count(req.write_data);
                    end
                    REG_CURRENT:
                    begin
                        count_next = '0;
                        flag_next  = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            REQ_READ:
            begin
                case (req.reg_index)
                    REG_CTRL:
                    begin
                        rsp.read_data = ctrl_read;
                        flag_next     = 1'b0;
                    end
                    REG_RELOAD:  rsp.read_data = count_to_field(reload_reg);
                    REG_CURRENT: rsp.read_data = count_to_field(count_reg);
                    default:     rsp.read_data = count_to_field(elapsed);
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            reload_reg  <= '0;
            en_reg      <= 1'b0;
            ie_reg      <= 1'b0;
            clk_sel_reg <= 1'b0;
            os_reg      <= 1'b0;
            flag_reg    <= 1'b0;
        end
        else if (step)
        begin
            count_reg   <= count_next;
            reload_reg  <= reload_next;
            en_reg      <= en_next;
            ie_reg      <= ie_next;
            clk_sel_reg <= clk_sel_next;
            os_reg      <= os_next;
            flag_reg    <= flag_next;
        end
    end

endmodule

// ----- hw/rtl/reload_down_counter_timer.sv -----
// ----------------------------------------------------------------------------
// reload_down_counter_timer
// Reload down-counter timer with control, reload, current and elapsed
// registers, driven by a stream of tick, write and read requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tuser carries req_type and reg_index, tdata carries
//   write_data. Every request yields exactly one result on m_axis: tdata is
//   read_data (zero unless a read), tuser is irq_pulse.
//   Path: an accepted request is held in the input register, then processed
//   against the timer state into the output register, which drives m_axis.
//   Throughput: one request per cycle unless m_axis stalls; the decrement,
//   reload compare and register mux are combinational logic.
//   Stall: while m_axis_tready is low the result holds; one more request
//   waits in the input register, then s_axis_tready drops. No request is
//   lost or repeated.
//   Reset: rst_n clears all timer state and both stages; the first request
//   can be accepted in the cycle after rst_n rises.
// ----------------------------------------------------------------------------
`include "reload_down_counter_timer_assert.svh"

module reload_down_counter_timer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] write_data
    input  logic [3:0]  s_axis_tuser,   // [1:0] req_type, [3:2] reg_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [23:0] read_data
    output logic [0:0]  m_axis_tuser    // [0] irq_pulse
);

    import rdct_pkg::*;

    logic in_valid_reg, in_valid_next;
    req_t in_req_reg;
    logic out_valid_reg, out_valid_next;
    rsp_t out_rsp_reg;
    rsp_t core_rsp;
    logic advance;
    logic accept;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    rdct_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (in_req_reg),
        .rsp   (core_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_req_reg.req_type   <= s_axis_tuser[1:0];
            in_req_reg.reg_index  <= s_axis_tuser[3:2];
            in_req_reg.write_data <= s_axis_tdata;
        end
        if (advance)
        begin
            out_rsp_reg <= core_rsp;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_rsp_reg.read_data;
    assign m_axis_tuser[0] = out_rsp_reg.irq_pulse;

    `RDCT_ASSERT(a_irq_no_data, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0), "irq with read data")
    `RDCT_ASSERT(a_stall_holds_in, (in_valid_reg && !advance) |=> in_valid_reg, "pending request dropped")
    `RDCT_ASSERT(a_ready_low_full, !s_axis_tready |-> (in_valid_reg && out_valid_reg), "ready low with room")
    `RDCT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!m_axis_tvalid && s_axis_tready), "stages not empty")

endmodule

// ----- test/tb_reload_down_counter_timer.sv -----
// ----------------------------------------------------------------------------
// tb_reload_down_counter_timer
// Stream-level test of the reload down-counter timer. A short directed list
// is followed by random timer programs: a reload, a control word and a burst
// of ticks mixed with reads and writes. The bursts run in phases with
// different amounts of sender idling and receiver stalling. Each accepted
// request is run through a local model of the timer, and every response is
// checked field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_reload_down_counter_timer;
    timeunit 1ns;
    timeprecision 1ps;

    import rdct_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [3:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    req_t req_pending_q[$];
    rsp_t rsp_due_q[$];

    int n_queued       = 0;
    int n_accepted     = 0;
    int err_count      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit recv_hold      = 1'b0;

    // timer state as the block should hold it
    count_t count_q  = '0;
    count_t reload_q = '0;
    logic   en_q     = 1'b0;
    logic   ie_q     = 1'b0;
    logic   clksel_q = 1'b0;
    logic   os_q     = 1'b0;
    logic   flag_q   = 1'b0;

    reload_down_counter_timer u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic req_t mk_req(input logic [1:0] kind, input logic [1:0] idx,
                                    input field_t data);
        req_t r;
        r.req_type   = kind;
        r.reg_index  = idx;
        r.write_data = data;
        return r;
    endfunction

    function automatic rsp_t timer_respond(input req_t r);
        rsp_t o;
        o = '0;
        case (r.req_type)
            REQ_TICK:
            begin
                if (en_q)
                begin
                    if (count_q == '0)
                        count_q = reload_q;
                    else
                    begin
                        count_q = count_q - 1'b1;
                        if (count_q == '0)
                        begin
                            flag_q      = 1'b1;
                            o.irq_pulse = ie_q;
                            // one-shot: stop after the pulse is decided
                            if (os_q)
                            begin
                                en_q     = 1'b0;
                                ie_q     = 1'b0;
                                reload_q = '0;
                                count_q  = '0;
                            end
                        end
                    end
                end
            end
            REQ_WRITE:
            begin
                case (r.reg_index)
                    REG_CTRL:
                    begin
                        en_q     = r.write_data[CTRL_EN_BIT];
                        ie_q     = r.write_data[CTRL_IE_BIT];
                        clksel_q = r.write_data[CTRL_CLK_BIT];
                        os_q     = r.write_data[CTRL_OS_BIT];
                    end
                    REG_RELOAD:  reload_q = count_t'(r.write_data);
                    REG_CURRENT:
                    begin
                        count_q = '0;
                        flag_q  = 1'b0;
                    end
                    default: ;
                endcase
            end
            REQ_READ:
            begin
                case (r.reg_index)
                    REG_CTRL:
                    begin
                        o.read_data[CTRL_EN_BIT]   = en_q;
                        o.read_data[CTRL_IE_BIT]   = ie_q;
                        o.read_data[CTRL_CLK_BIT]  = clksel_q;
                        o.read_data[CTRL_OS_BIT]   = os_q;
                        o.read_data[CTRL_FLAG_BIT] = flag_q;
                        flag_q = 1'b0;
                    end
                    REG_RELOAD:  o.read_data = field_t'(reload_q);
                    REG_CURRENT: o.read_data = field_t'(count_q);
                    default:     o.read_data = field_t'(count_t'(reload_q - count_q));
                endcase
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic queue_req(input logic [1:0] kind, input logic [1:0] idx, input field_t data);
        req_pending_q.push_back(mk_req(kind, idx, data));
        n_queued++;
    endtask

    // program a reload and control word, then run a burst of ticks
    task automatic add_timer_burst();
        int     pick;
        field_t ctrl;
        pick = $urandom_range(99);
        if (pick < 70)
            queue_req(REQ_WRITE, REG_RELOAD, field_t'($urandom_range(6)));
        else if (pick < 90)
            queue_req(REQ_WRITE, REG_RELOAD, field_t'($urandom_range(40, 7)));
        else
            queue_req(REQ_WRITE, REG_RELOAD, field_t'($urandom));
        if ($urandom_range(1) != 0)
            queue_req(REQ_WRITE, REG_CURRENT, field_t'($urandom));
        ctrl = field_t'($urandom);
        if ($urandom_range(9) != 0)
            ctrl[CTRL_EN_BIT] = 1'b1;
        queue_req(REQ_WRITE, REG_CTRL, ctrl);
        repeat ($urandom_range(24, 1))
        begin
            pick = $urandom_range(99);
            if (pick < 78)
                queue_req(REQ_TICK, 2'($urandom), field_t'($urandom));
            else if (pick < 90)
                queue_req(REQ_READ, 2'($urandom), field_t'($urandom));
            else if (pick < 95)
                queue_req(REQ_WRITE, 2'($urandom_range(3, 2)), field_t'($urandom));
            else
                queue_req(2'($urandom), 2'($urandom), field_t'($urandom));
        end
        if ($urandom_range(1) != 0)
            queue_req(REQ_READ, REG_CTRL, field_t'($urandom));
    endtask

    task automatic add_directed();
        queue_req(REQ_READ,  REG_CTRL,    '0);
        queue_req(REQ_READ,  REG_ELAPSED, '0);
        // zero reload: reloads to zero, never fires
        queue_req(REQ_WRITE, REG_RELOAD,  '0);
        queue_req(REQ_WRITE, REG_CTRL,    24'h000003);
        queue_req(REQ_TICK,  REG_CTRL,    '0);
        queue_req(REQ_TICK,  REG_ELAPSED, 24'hFFFFFF);
        queue_req(REQ_READ,  REG_CURRENT, '0);
        // one-shot with interrupt, upper control bits set and ignored
        queue_req(REQ_WRITE, REG_RELOAD,  24'd3);
        queue_req(REQ_WRITE, REG_CTRL,    24'hFFFFFF);
        repeat (4) queue_req(REQ_TICK, REG_CTRL, '0);
        queue_req(REQ_TICK,  REG_CTRL,    '0);
        queue_req(REQ_READ,  REG_CTRL,    '0);
        queue_req(REQ_READ,  REG_CTRL,    '0);
        queue_req(REQ_READ,  REG_RELOAD,  '0);
        // periodic at full-scale reload
        queue_req(REQ_WRITE, REG_RELOAD,  24'hFFFFFF);
        queue_req(REQ_WRITE, REG_CTRL,    24'h000003);
        queue_req(REQ_TICK,  REG_CTRL,    '0);
        queue_req(REQ_READ,  REG_ELAPSED, '0);
        queue_req(REQ_WRITE, REG_CURRENT, 24'hFFFFFF);
        queue_req(REQ_WRITE, REG_ELAPSED, 24'h123456);
        queue_req(REQ_NONE,  REG_RELOAD,  24'hFFFFFF);
        queue_req(REQ_READ,  REG_ELAPSED, '0);
    endtask

    task automatic wait_drained();
        while (req_pending_q.size() != 0 || s_axis_tvalid || rsp_due_q.size() != 0)
            @(negedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        req_t nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                rsp_due_q.push_back(timer_respond(mk_req(s_axis_tuser[1:0], s_axis_tuser[3:2],
                                                         s_axis_tdata)));
                n_accepted <= n_accepted + 1;
            end
            if (req_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = req_pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.write_data;
                s_axis_tuser  <= {nxt.reg_index, nxt.req_type};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (rsp_due_q.size() == 0)
                report_mismatch($sformatf("response with none due, tdata %h", m_axis_tdata));
            else
            begin
                want = rsp_due_q.pop_front();
                if (m_axis_tdata !== want.read_data)
                    report_mismatch($sformatf("read_data %h, want %h",
                                              m_axis_tdata, want.read_data));
                if (m_axis_tuser[0] !== want.irq_pulse)
                    report_mismatch($sformatf("irq_pulse %b, want %b",
                                              m_axis_tuser[0], want.irq_pulse));
            end
        end
    end

    // long receiver hold-off while the sender keeps going
    initial
    begin
        while (n_accepted < 80)
            @(negedge clk);
        recv_hold = 1'b1;
        repeat (200) @(negedge clk);
        recv_hold = 1'b0;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    add_directed();
                end
                1:
                begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 71;
                end
                default:
                begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            while (n_queued < (ph + 1) * 420)
                add_timer_burst();
            // sender pauses until every response is back
            wait_drained();
        end
        repeat (10) @(negedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/rdct_pkg.sv
hw/rtl/rdct_core.sv
hw/rtl/reload_down_counter_timer.sv
test/tb_reload_down_counter_timer.sv
